// ----- design/arf_pkg.sv -----
package arf_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 11;
    localparam int OP_W   = 2;
    localparam int NCNT_W = 7;
    localparam int CIDX_W = 2;
    localparam int TOT_W  = 32;

    localparam int RING_DEPTH_DEF  = 1024;
    localparam int MAX_REQUEST_DEF = 64;

    localparam logic [CFG_W-1:0] MAX_BUF_RST = 11'd1024;
    localparam logic [CFG_W-1:0] RETAIN_RST  = 11'd256;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RESET = 2'd2
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ONLINE  = 2'd0,
        CFG_PREBUF  = 2'd1,
        CFG_MAXBUF  = 2'd2,
        CFG_RETAIN  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TRIM,
        S_PRIME,
        S_RFIRST,
        S_REMIT,
        S_ZERO,
        S_STAT
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] sample_out;
        logic              sample_real;
        logic              last;
        logic              write_accepted;
        logic [CFG_W-1:0]  fill_level;
        logic              primed_flag;
        logic [TOT_W-1:0]  overrun_count;
        logic [TOT_W-1:0]  underrun_count;
    } t_result;

endpackage

// ----- design/arf_in_if.sv -----
interface arf_in_if import arf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] sample;
    logic [NCNT_W-1:0] frame_count;

    modport source (output valid, input ready, output opcode, output sample,
                    output frame_count);
    modport sink (input valid, output ready, input opcode, input sample,
                  input frame_count);
endinterface

// ----- design/arf_out_if.sv -----
interface arf_out_if import arf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample_out;
    logic              sample_real;
    logic              last;
    logic              write_accepted;
    logic [CFG_W-1:0]  fill_level;
    logic              primed_flag;
    logic [TOT_W-1:0]  overrun_count;
    logic [TOT_W-1:0]  underrun_count;

    modport source (output valid, input ready, output sample_out, output sample_real,
                    output last, output write_accepted, output fill_level,
                    output primed_flag, output overrun_count, output underrun_count);
    modport sink (input valid, output ready, input sample_out, input sample_real,
                  input last, input write_accepted, input fill_level,
                  input primed_flag, input overrun_count, input underrun_count);
endinterface

// ----- design/arf_ram.sv -----
module arf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/arf_core.sv -----
module arf_core import arf_pkg::*; #(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    arf_in_if.sink            i_item,
    output logic              o_res_vld,
    input  logic              i_res_rdy,
    output t_result           o_res
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int SUM_W  = PTR_W + 1;
    localparam int TOT_X  = TOT_W + 1;
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
    localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(RING_DEPTH);
    localparam logic [NCNT_W-1:0] NREQ_MAX  = NCNT_W'(MAX_REQUEST);

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [DATA_W-1:0]   r_smp;
    logic [NCNT_W-1:0]   r_n;
    logic [NCNT_W-1:0]   r_idx;
    logic [NCNT_W-1:0]   r_cnt;
    logic                r_wacc;
    logic [PTR_W-1:0]    r_wp;
    logic [PTR_W-1:0]    r_rp;
    logic [FILL_W-1:0]   r_fill;
    logic                r_primed;
    logic [TOT_W-1:0]    r_ovr;
    logic [TOT_W-1:0]    r_und;
    logic                r_online;
    logic [CFG_W-1:0]    r_pre;
    logic [CFG_W-1:0]    r_maxb;
    logic [CFG_W-1:0]    r_dret;

    logic [CMP_W-1:0]    w_fill_c, w_pre_c, w_max_c, w_dret_c, w_keep_c, w_n_c;
    logic [FILL_W-1:0]   w_keep, w_drop;
    logic [SUM_W-1:0]    w_rp_sum;
    logic [PTR_W-1:0]    w_rp_trim, w_rp_inc, w_wp_inc;
    logic [TOT_X-1:0]    w_ovr_drop_sum, w_ovr_one_sum, w_und_sum;
    logic [TOT_W-1:0]    w_ovr_drop, w_ovr_one, w_und_new;
    logic [NCNT_W-1:0]   w_cnt, w_pad, w_idx_nxt, w_n_sat;
    logic                w_do_trim, w_wait_prime, w_full;
    logic                w_ram_we, w_ram_re;
    logic [DATA_W-1:0]   w_rdata;

    always_comb begin
        w_fill_c = CMP_W'(r_fill);
        w_pre_c  = CMP_W'(r_pre);
        w_max_c  = CMP_W'(r_maxb);
        w_dret_c = CMP_W'(r_dret);
        w_n_c    = CMP_W'(r_n);
        w_keep_c = (w_pre_c != '0) ? w_pre_c : w_dret_c;
        if (w_keep_c > w_max_c) begin
            w_keep_c = w_max_c;
        end
        w_keep   = FILL_W'(w_keep_c);
        w_drop   = r_fill - w_keep;
        w_rp_sum = {1'b0, r_rp} + SUM_W'(w_drop);
        w_rp_trim = (w_rp_sum >= SUM_DEPTH) ? PTR_W'(w_rp_sum - SUM_DEPTH)
                                            : w_rp_sum[PTR_W-1:0];
        w_rp_inc = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
        w_wp_inc = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;

        w_ovr_drop_sum = {1'b0, r_ovr} + TOT_X'(w_drop);
        w_ovr_drop     = w_ovr_drop_sum[TOT_W] ? '1 : w_ovr_drop_sum[TOT_W-1:0];
        w_ovr_one_sum  = {1'b0, r_ovr} + TOT_X'(1);
        w_ovr_one      = w_ovr_one_sum[TOT_W] ? '1 : w_ovr_one_sum[TOT_W-1:0];

        w_cnt     = (w_n_c < w_fill_c) ? r_n : NCNT_W'(r_fill);
        w_pad     = r_n - w_cnt;
        w_und_sum = {1'b0, r_und} + TOT_X'(w_pad);
        w_und_new = w_und_sum[TOT_W] ? '1 : w_und_sum[TOT_W-1:0];

        w_idx_nxt    = r_idx + 1'b1;
        w_do_trim    = w_fill_c > w_max_c;
        w_wait_prime = !r_primed && (w_fill_c < w_pre_c);
        w_full       = r_fill >= FILL_FULL;
        w_n_sat      = (i_item.frame_count > NREQ_MAX) ? NREQ_MAX : i_item.frame_count;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_READ) begin
                    if (r_n == '0) begin
                        n_state = S_IDLE;
                    end else if (!r_online) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_TRIM;
                    end
                end else begin
                    n_state = S_STAT;
                end
            end
            S_TRIM: n_state = S_PRIME;
            S_PRIME: begin
                if (w_wait_prime || w_cnt == '0) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_RFIRST;
                end
            end
            S_RFIRST: n_state = S_REMIT;
            S_REMIT: begin
                if (i_res_rdy) begin
                    if (w_idx_nxt < r_cnt) begin
                        n_state = S_REMIT;
                    end else if (w_idx_nxt < r_n) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ZERO: begin
                if (i_res_rdy && w_idx_nxt == r_n) begin
                    n_state = S_IDLE;
                end
            end
            S_STAT: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_item.ready = 1'b0;
        o_res_vld    = 1'b0;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;
        o_res.sample_out     = '0;
        o_res.sample_real    = 1'b0;
        o_res.last           = (w_idx_nxt == r_n);
        o_res.write_accepted = 1'b0;
        unique case (r_state)
            S_IDLE: i_item.ready = 1'b1;
            S_EXEC: w_ram_we = (r_op == OP_WRITE) && !w_full;
            S_RFIRST: w_ram_re = 1'b1;
            S_REMIT: begin
                o_res_vld         = 1'b1;
                o_res.sample_out  = w_rdata;
                o_res.sample_real = 1'b1;
                w_ram_re          = i_res_rdy && (w_idx_nxt < r_cnt);
            end
            S_ZERO: o_res_vld = 1'b1;
            S_STAT: begin
                o_res_vld            = 1'b1;
                o_res.last           = 1'b1;
                o_res.write_accepted = r_wacc;
            end
            default: ;
        endcase
        o_res.fill_level     = w_fill_c[CFG_W-1:0];
        o_res.primed_flag    = r_primed;
        o_res.overrun_count  = r_ovr;
        o_res.underrun_count = r_und;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_fill   <= '0;
            r_primed <= 1'b0;
            r_ovr    <= '0;
            r_und    <= '0;
            r_online <= 1'b0;
            r_pre    <= '0;
            r_maxb   <= MAX_BUF_RST;
            r_dret   <= RETAIN_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ONLINE: r_online <= i_cfg_data[0];
                    CFG_PREBUF: r_pre    <= i_cfg_data;
                    CFG_MAXBUF: r_maxb   <= i_cfg_data;
                    CFG_RETAIN: r_dret   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_op   <= i_item.opcode;
                        r_smp  <= i_item.sample;
                        r_n    <= w_n_sat;
                        r_idx  <= '0;
                        r_wacc <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_WRITE) begin
                        if (!w_full) begin
                            r_wp   <= w_wp_inc;
                            r_fill <= r_fill + 1'b1;
                            r_wacc <= 1'b1;
                        end else begin
                            r_ovr <= w_ovr_one;
                        end
                    end else if (r_op == OP_RESET) begin
                        r_rp   <= r_wp;
                        r_fill <= '0;
                        r_ovr  <= '0;
                        r_und  <= '0;
                    end
                end
                S_TRIM: begin
                    if (w_do_trim) begin
                        r_rp     <= w_rp_trim;
                        r_fill   <= w_keep;
                        r_ovr    <= w_ovr_drop;
                        r_primed <= 1'b0;
                    end
                end
                S_PRIME: begin
                    if (!w_wait_prime) begin
                        r_cnt  <= w_cnt;
                        r_fill <= r_fill - FILL_W'(w_cnt);
                        if (w_cnt < r_n) begin
                            r_und    <= w_und_new;
                            r_primed <= 1'b0;
                        end else begin
                            r_primed <= 1'b1;
                        end
                    end
                end
                S_RFIRST: r_rp <= w_rp_inc;
                S_REMIT: begin
                    if (i_res_rdy) begin
                        r_idx <= w_idx_nxt;
                        if (w_idx_nxt < r_cnt) begin
                            r_rp <= w_rp_inc;
                        end
                    end
                end
                S_ZERO: begin
                    if (i_res_rdy) begin
                        r_idx <= w_idx_nxt;
                    end
                end
                default: ;
            endcase
        end
    end

    arf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_smp),
        .i_re    (w_ram_re),
        .i_raddr (r_rp),
        .o_rdata (w_rdata)
    );

endmodule

// ----- design/audio_ring_fifo_with_priming.sv -----
// Ring FIFO of 32-bit audio samples with reader priming. Opcode 0 stores one sample (or counts
// an overrun when full), opcode 1 asks for frame_count frames (capped at MAX_REQUEST), opcode 2
// empties the ring and clears both totals; every write, reset or unused opcode gives one status
// transaction, a read gives one transaction per frame, real samples first and zero padding after.
// The block takes one item at a time. A read passes through decode, trim and priming, then a first
// memory read; while the sink does not stall it then gives one sample a cycle out of the single
// read port of the sample memory. A read with no real sample skips the memory read, and one with
// the engine offline skips trim and priming. Status fields in each result show the state after
// the whole item. The sample memory needs no clearing pass after reset. Configuration must be
// written only while idle; the block itself does not enforce it.
module audio_ring_fifo_with_priming import arf_pkg::*; #(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    arf_in_if.sink            i_item,
    arf_out_if.source         o_result
);

    logic    w_res_vld;
    logic    w_res_rdy;
    t_result w_res;
    logic    r_out_vld;
    t_result r_out;

    arf_core #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .o_res_vld  (w_res_vld),
        .i_res_rdy  (w_res_rdy),
        .o_res      (w_res)
    );

    assign w_res_rdy = !r_out_vld || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_rdy) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld && w_res_rdy) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.sample_out     = r_out.sample_out;
    assign o_result.sample_real    = r_out.sample_real;
    assign o_result.last           = r_out.last;
    assign o_result.write_accepted = r_out.write_accepted;
    assign o_result.fill_level     = r_out.fill_level;
    assign o_result.primed_flag    = r_out.primed_flag;
    assign o_result.overrun_count  = r_out.overrun_count;
    assign o_result.underrun_count = r_out.underrun_count;

`ifndef SYNTHESIS
    a_accept_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |-> !w_res_vld)
        else $error("item accepted while a result is pending");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("second item accepted back to back");

    a_write_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.write_accepted |-> o_result.last && !o_result.sample_real)
        else $error("write result marked as read sample or not last");
`endif

endmodule

// ----- dv/arf_result_checker.sv -----
`timescale 1ns / 100ps

module arf_result_checker import arf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    arf_in_if                 i_item,
    arf_out_if                i_result,
    output int unsigned       o_fail_count,
    output int unsigned       o_pending
);

    localparam int PTR_W = $clog2(RING_DEPTH_DEF);

    logic [DATA_W-1:0] ring_mem [RING_DEPTH_DEF];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [CFG_W-1:0]  fill;
    logic              primed;
    logic [TOT_W-1:0]  overruns;
    logic [TOT_W-1:0]  underruns;

    logic              online;
    logic [CFG_W-1:0]  prebuf_frames;
    logic [CFG_W-1:0]  max_buffered;
    logic [CFG_W-1:0]  retain_frames;

    t_result           due_results [$];
    int unsigned       mismatches = 0;

    function automatic logic [TOT_W-1:0] add_sat(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b);
        logic [TOT_W:0] sum;
        sum = a + b;
        return sum[TOT_W] ? '1 : sum[TOT_W-1:0];
    endfunction

    function automatic void push_result(logic [DATA_W-1:0] smp, logic is_real, logic is_last,
                                        logic stored);
        t_result r;
        r.sample_out     = smp;
        r.sample_real    = is_real;
        r.last           = is_last;
        r.write_accepted = stored;
        r.fill_level     = fill;
        r.primed_flag    = primed;
        r.overrun_count  = overruns;
        r.underrun_count = underruns;
        due_results.push_back(r);
    endfunction

    function automatic void push_zeros(int unsigned n);
        for (int i = 0; i < n; i++) begin
            push_result('0, 1'b0, i == n - 1, 1'b0);
        end
    endfunction

    task automatic step_ring(logic [OP_W-1:0] op, logic [DATA_W-1:0] smp,
                             logic [NCNT_W-1:0] frames);
        int unsigned       n;
        int unsigned       keep;
        int unsigned       give;
        logic [DATA_W-1:0] taken [MAX_REQUEST_DEF];
        n = (frames > MAX_REQUEST_DEF) ? MAX_REQUEST_DEF : frames;
        case (op)
            OP_WRITE: begin
                if (fill < RING_DEPTH_DEF) begin
                    ring_mem[wr_ptr] = smp;
                    wr_ptr++;
                    fill++;
                    push_result('0, 1'b0, 1'b1, 1'b1);
                end else begin
                    overruns = add_sat(overruns, 1);
                    push_result('0, 1'b0, 1'b1, 1'b0);
                end
            end
            OP_RESET: begin
                rd_ptr    = wr_ptr;
                fill      = '0;
                overruns  = '0;
                underruns = '0;
                push_result('0, 1'b0, 1'b1, 1'b0);
            end
            OP_READ: if (n != 0) begin
                if (!online) begin
                    push_zeros(n);
                end else begin
                    if (fill > max_buffered) begin
                        keep = (prebuf_frames != 0) ? prebuf_frames : retain_frames;
                        if (keep > max_buffered) keep = max_buffered;
                        rd_ptr   = rd_ptr + PTR_W'(fill - keep);
                        overruns = add_sat(overruns, TOT_W'(fill - keep));
                        fill     = CFG_W'(keep);
                        primed   = 1'b0;
                    end
                    if (!primed && fill < prebuf_frames) begin
                        push_zeros(n);
                    end else begin
                        primed = 1'b1;
                        give = (n < fill) ? n : fill;
                        for (int i = 0; i < give; i++) begin
                            taken[i] = ring_mem[rd_ptr];
                            rd_ptr++;
                        end
                        fill = fill - CFG_W'(give);
                        if (give < n) begin
                            underruns = add_sat(underruns, TOT_W'(n - give));
                            primed    = 1'b0;
                        end
                        for (int i = 0; i < n; i++) begin
                            push_result((i < give) ? taken[i] : '0, i < give, i == n - 1, 1'b0);
                        end
                    end
                end
            end
            default: push_result('0, 1'b0, 1'b1, 1'b0);
        endcase
    endtask

    function automatic void check_field(string name, logic [TOT_W-1:0] want,
                                        logic [TOT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (due_results.size() == 0) begin
            $error("result transaction with no expected result pending");
            mismatches++;
        end else begin
            want = due_results.pop_front();
            check_field("sample_out", want.sample_out, i_result.sample_out);
            check_field("sample_real", want.sample_real, i_result.sample_real);
            check_field("last", want.last, i_result.last);
            check_field("write_accepted", want.write_accepted, i_result.write_accepted);
            check_field("fill_level", want.fill_level, i_result.fill_level);
            check_field("primed_flag", want.primed_flag, i_result.primed_flag);
            check_field("overrun_count", want.overrun_count, i_result.overrun_count);
            check_field("underrun_count", want.underrun_count, i_result.underrun_count);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr        = '0;
            rd_ptr        = '0;
            fill          = '0;
            primed        = 1'b0;
            overruns      = '0;
            underruns     = '0;
            online        = 1'b0;
            prebuf_frames = '0;
            max_buffered  = MAX_BUF_RST;
            retain_frames = RETAIN_RST;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ONLINE: online        = i_cfg_data[0];
                    CFG_PREBUF: prebuf_frames = i_cfg_data;
                    CFG_MAXBUF: max_buffered  = i_cfg_data;
                    CFG_RETAIN: retain_frames = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) check_result();
            if (i_item.valid && i_item.ready) begin
                step_ring(i_item.opcode, i_item.sample, i_item.frame_count);
            end
        end
        o_fail_count = mismatches;
        o_pending    = due_results.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench import arf_pkg::*; ();

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 80;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_data;
    int unsigned       fail_count;
    int unsigned       pending;
    int unsigned       burst_left;

    arf_in_if  item_ch ();
    arf_out_if result_ch ();

    audio_ring_fifo_with_priming i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    arf_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : result_stall
        int unsigned high_len;
        int unsigned low_len;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            high_len = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            low_len  = $urandom_range(1, 12);
            result_ch.ready <= 1'b1;
            repeat (high_len) @(posedge i_clk);
            result_ch.ready <= 1'b0;
            repeat (low_len) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("audio_ring_fifo_with_priming test failed");
        $finish;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] smp,
                             input logic [NCNT_W-1:0] frames);
        if (burst_left == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 20);
        end
        burst_left--;
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= op;
        item_ch.sample      <= smp;
        item_ch.frame_count <= frames;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic settle_ring();
        item_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic online, input logic [CFG_W-1:0] prebuf,
                              input logic [CFG_W-1:0] maxbuf, input logic [CFG_W-1:0] retain);
        settle_ring();
        write_reg(CFG_ONLINE, CFG_W'(online));
        write_reg(CFG_PREBUF, prebuf);
        write_reg(CFG_MAXBUF, maxbuf);
        write_reg(CFG_RETAIN, retain);
    endtask

    task automatic random_item(input int unsigned max_n);
        int unsigned       pick;
        logic [NCNT_W-1:0] frames;
        pick   = $urandom_range(0, 99);
        frames = ($urandom_range(0, 9) == 0) ? NCNT_W'($urandom_range(0, 127))
                                             : NCNT_W'($urandom_range(1, max_n));
        if (pick < 72) begin
            send_item(OP_WRITE, $urandom(), frames);
        end else if (pick < 95) begin
            send_item(OP_READ, $urandom(), frames);
        end else if (pick < 98) begin
            send_item(OP_RESET, $urandom(), frames);
        end else begin
            send_item(OP_SPARE, $urandom(), frames);
        end
    endtask

    task automatic run_phase(input logic online, input logic [CFG_W-1:0] prebuf,
                             input logic [CFG_W-1:0] maxbuf, input logic [CFG_W-1:0] retain,
                             input int unsigned max_n, input int unsigned count);
        set_config(online, prebuf, maxbuf, retain);
        repeat (count) random_item(max_n);
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_ONLINE;
        cfg_data            <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.opcode      <= OP_WRITE;
        item_ch.sample      <= '0;
        item_ch.frame_count <= '0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // engine offline after reset: writes still land, reads give zeros
        send_item(OP_WRITE, 32'h0000_0000, 7'd1);
        send_item(OP_WRITE, 32'hFFFF_FFFF, 7'd127);
        send_item(OP_WRITE, 32'hA5A5_5A5A, 7'd64);
        send_item(OP_READ, 32'hFFFF_FFFF, 7'd3);
        send_item(OP_READ, 32'h0, 7'd0);
        send_item(OP_SPARE, 32'h1234_5678, 7'd5);
        send_item(OP_RESET, 32'h0, 7'd2);

        // priming wait, trim down to the prebuffer amount, short read
        set_config(1'b1, 11'd2, 11'd4, 11'd0);
        send_item(OP_READ, $urandom(), 7'd2);
        send_item(OP_WRITE, 32'h7FFF_FFFF, 7'd0);
        send_item(OP_WRITE, 32'h8000_0000, 7'd0);
        send_item(OP_WRITE, 32'h0000_0001, 7'd0);
        send_item(OP_READ, $urandom(), 7'd1);
        send_item(OP_WRITE, $urandom(), 7'd0);
        send_item(OP_WRITE, $urandom(), 7'd0);
        send_item(OP_WRITE, $urandom(), 7'd0);
        send_item(OP_READ, $urandom(), 7'd127);
        send_item(OP_SPARE, $urandom(), 7'd64);
        send_item(OP_RESET, $urandom(), 7'd0);

        run_phase(1'b0, 11'd3, 11'd16, 11'd8, 8, 45);
        run_phase(1'b1, 11'd0, 11'd12, 11'd1024, 8, 45);
        run_phase(1'b1, 11'd6, 11'd20, 11'd3, 8, 45);
        run_phase(1'b1, 11'd0, 11'd1024, 11'd5, 8, 45);
        repeat (3) begin
            run_phase(1'b1, CFG_W'($urandom_range(0, 16)), CFG_W'($urandom_range(1, 48)),
                      CFG_W'($urandom_range(0, 1024)), 8, 45);
        end

        // a limit of one with nothing retained drops the whole ring
        run_phase(1'b1, 11'd0, 11'd1, 11'd0, 4, 45);

        settle_ring();
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("audio_ring_fifo_with_priming test passed");
        end else begin
            $display("audio_ring_fifo_with_priming test failed");
        end
        $finish;
    end

endmodule
